>>> rtl/core/rgb_mosaic_2x2_block_average_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 2x2 block average mosaic
// Both macros expect clk and rst_n to be in scope at the point of use.
// ----------------------------------------------------------------------------
`ifndef RGB_MOSAIC_2X2_BLOCK_AVERAGE_MACROS_SVH
`define RGB_MOSAIC_2X2_BLOCK_AVERAGE_MACROS_SVH

// Same-cycle implication
`define RGBM_ASSERT_NOW(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication
`define RGBM_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

>>> rtl/core/rgbm_pkg.sv
// ----------------------------------------------------------------------------
// rgbm_pkg
// Types and fixed constants shared by the 2x2 block average mosaic.
// ----------------------------------------------------------------------------
package rgbm_pkg;

  localparam int CH_W    = 8;   // colour channel
  localparam int SUM_W   = 9;   // sum of two channel values
  localparam int PX_W    = 10;  // output column
  localparam int PY_W    = 12;  // output row
  localparam int CFG_W_W = 11;  // image_width register
  localparam int CFG_H_W = 13;  // image_height register
  localparam int GEO_W_W = 14;  // clamped width, covers every MAX_WIDTH
  localparam int GEO_H_W = 17;  // clamped height, covers every MAX_HEIGHT

  localparam logic [CFG_W_W-1:0] WIDTH_RST  = CFG_W_W'(1024);
  localparam logic [CFG_H_W-1:0] HEIGHT_RST = CFG_H_W'(768);

  // Register indexes (byte address bit 2)
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } in_pixel_t;

  typedef struct packed {
    logic [PX_W-1:0] pixel_x;
    logic [PY_W-1:0] pixel_y;
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            tile_last;
  } out_pixel_t;

  // Clamped geometry plus a restart strobe on any register write
  typedef struct packed {
    logic [GEO_W_W-1:0] width;
    logic [GEO_H_W-1:0] height;
    logic               restart;
  } geom_t;

  // One finished tile: top-left corner, shape and averaged colour
  typedef struct packed {
    logic [PX_W-1:0] x0;
    logic [PY_W-1:0] y0;
    logic            tw2;
    logic            th2;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } grp_t;

endpackage

>>> rtl/core/rgbm_regs.sv
// ----------------------------------------------------------------------------
// rgbm_regs
// Geometry registers on the configuration port, with range clamping.
// ----------------------------------------------------------------------------
module rgbm_regs
  import rgbm_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output geom_t       geom
);

  logic               wr_en;
  logic               idx;
  logic [CFG_W_W-1:0] width_r;
  logic [CFG_H_W-1:0] height_r;

  assign pready = 1'b1;
  assign idx    = paddr[2];
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (wr_en) begin
      case (idx)
        REG_WIDTH:  width_r  <= pwdata[CFG_W_W-1:0];
        REG_HEIGHT: height_r <= pwdata[CFG_H_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WIDTH:  prdata = 32'(width_r);
      REG_HEIGHT: prdata = 32'(height_r);
      default:    prdata = '0;
    endcase
  end

  // zero acts as one, oversize acts as the maximum
  assign geom.width  = (width_r == '0) ? GEO_W_W'(1) :
                       (32'(width_r) > MAX_WIDTH) ? GEO_W_W'(MAX_WIDTH) :
                       GEO_W_W'(width_r);
  assign geom.height = (height_r == '0) ? GEO_H_W'(1) :
                       (32'(height_r) > MAX_HEIGHT) ? GEO_H_W'(MAX_HEIGHT) :
                       GEO_H_W'(height_r);
  assign geom.restart = wr_en;

endmodule

>>> rtl/core/rgbm_tile.sv
// ----------------------------------------------------------------------------
// rgbm_tile
// Raster position tracking, pair sums, upper-row sum store and tile average.
// ----------------------------------------------------------------------------
module rgbm_tile
  import rgbm_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  input  geom_t     geom,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_pixel_t in_data,
  input  logic      grp_ready,
  output logic      grp_load,
  output grp_t      grp
);

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int PAIR_SLOTS = (MAX_WIDTH + 1) / 2;
  localparam int SLOT_W     = (PAIR_SLOTS > 1) ? $clog2(PAIR_SLOTS) : 1;
  localparam int MEM_W      = 3 * SUM_W;

  localparam logic [1:0] KIND_HOLD  = 2'd0;  // left pixel of a pair
  localparam logic [1:0] KIND_STORE = 2'd1;  // pair end on an upper tile row
  localparam logic [1:0] KIND_EMIT  = 2'd2;  // tile complete

  // input side
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              accept;
  logic              last_col, last_row;
  logic              pair_end, upper;
  logic [1:0]        a_kind;
  logic [SLOT_W-1:0] a_slot;

  // work stage
  logic              b_valid_r, b_valid_nxt;
  logic [1:0]        b_kind_r;
  in_pixel_t         b_pix_r;
  logic              b_tw2_r, b_th2_r;
  logic [PX_W-1:0]   b_x0_r;
  logic [PY_W-1:0]   b_y0_r;
  logic [SLOT_W-1:0] b_slot_r;
  in_pixel_t         held_r;
  logic              b_fire;

  // sum store
  logic [MEM_W-1:0]  mem [PAIR_SLOTS];
  logic [MEM_W-1:0]  rd_data_r;
  logic [MEM_W-1:0]  byp_data_r;
  logic              byp_hit_r;
  logic              wr_en;
  logic [MEM_W-1:0]  wr_data;
  logic [MEM_W-1:0]  up;

  logic [SUM_W-1:0]  sr, sg, sb;
  logic [SUM_W:0]    tr, tg, tb;
  logic [1:0]        sh;

  // ---------------- input side ----------------
  assign accept   = in_valid & in_ready;
  assign last_col = (GEO_W_W'(col_r) + GEO_W_W'(1)) >= geom.width;
  assign last_row = (GEO_H_W'(row_r) + GEO_H_W'(1)) >= geom.height;
  assign pair_end = col_r[0] | last_col;
  assign upper    = ~row_r[0] & ~last_row;
  assign a_kind   = !pair_end ? KIND_HOLD : (upper ? KIND_STORE : KIND_EMIT);
  assign a_slot   = SLOT_W'(col_r >> 1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (geom.restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  // ---------------- work stage ----------------
  assign b_fire      = b_valid_r & ((b_kind_r != KIND_EMIT) | grp_ready);
  assign in_ready    = ~b_valid_r | b_fire;
  assign b_valid_nxt = accept ? 1'b1 : (b_fire ? 1'b0 : b_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      b_valid_r <= 1'b0;
      held_r    <= '0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      b_valid_r <= b_valid_nxt;
      if (b_fire && b_kind_r == KIND_HOLD) begin
        held_r <= b_pix_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_kind_r <= a_kind;
      b_pix_r  <= in_data;
      b_tw2_r  <= col_r[0];
      b_th2_r  <= row_r[0];
      b_x0_r   <= PX_W'(col_r) & ~PX_W'(1);
      b_y0_r   <= PY_W'(row_r) & ~PY_W'(1);
      b_slot_r <= a_slot;
    end
  end

  // horizontal pair sums
  assign sr = SUM_W'(b_pix_r.red_in)   + (b_tw2_r ? SUM_W'(held_r.red_in)   : '0);
  assign sg = SUM_W'(b_pix_r.green_in) + (b_tw2_r ? SUM_W'(held_r.green_in) : '0);
  assign sb = SUM_W'(b_pix_r.blue_in)  + (b_tw2_r ? SUM_W'(held_r.blue_in)  : '0);

  assign wr_en   = b_fire & (b_kind_r == KIND_STORE);
  assign wr_data = {sr, sg, sb};

  // read at transfer, registered; forward a write to the same slot in that cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[b_slot_r] <= wr_data;
    end
    if (accept) begin
      rd_data_r  <= mem[a_slot];
      byp_hit_r  <= wr_en & (b_slot_r == a_slot);
      byp_data_r <= wr_data;
    end
  end

  assign up = byp_hit_r ? byp_data_r : rd_data_r;

  assign tr = (SUM_W+1)'(sr) + (b_th2_r ? (SUM_W+1)'(up[3*SUM_W-1:2*SUM_W]) : '0);
  assign tg = (SUM_W+1)'(sg) + (b_th2_r ? (SUM_W+1)'(up[2*SUM_W-1:SUM_W])   : '0);
  assign tb = (SUM_W+1)'(sb) + (b_th2_r ? (SUM_W+1)'(up[SUM_W-1:0])         : '0);
  assign sh = {1'b0, b_tw2_r} + {1'b0, b_th2_r};

  assign grp_load  = b_fire & (b_kind_r == KIND_EMIT);
  assign grp.x0    = b_x0_r;
  assign grp.y0    = b_y0_r;
  assign grp.tw2   = b_tw2_r;
  assign grp.th2   = b_th2_r;
  assign grp.red   = CH_W'(tr >> sh);
  assign grp.green = CH_W'(tg >> sh);
  assign grp.blue  = CH_W'(tb >> sh);

endmodule

>>> rtl/core/rgbm_emit.sv
// ----------------------------------------------------------------------------
// rgbm_emit
// Holds one finished tile and plays out its pixels, one transfer per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`include "rgb_mosaic_2x2_block_average_macros.svh"

module rgbm_emit
  import rgbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       grp_load,
  input  grp_t       grp,
  output logic       grp_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output out_pixel_t out_data
);

  grp_t grp_r;
  logic grp_valid_r;
  logic dx_r, dy_r;
  logic tile_last;
  logic xfer;

  assign tile_last = (dx_r == grp_r.tw2) & (dy_r == grp_r.th2);
  assign xfer      = grp_valid_r & out_ready;
  assign grp_ready = ~grp_valid_r | (out_ready & tile_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_valid_r <= 1'b0;
      dx_r        <= 1'b0;
      dy_r        <= 1'b0;
    end else if (grp_load) begin
      grp_valid_r <= 1'b1;
      dx_r        <= 1'b0;
      dy_r        <= 1'b0;
    end else if (xfer) begin
      if (tile_last) begin
        grp_valid_r <= 1'b0;
      end else if (dx_r != grp_r.tw2) begin
        dx_r <= 1'b1;
      end else begin
        dx_r <= 1'b0;
        dy_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp_load) begin
      grp_r <= grp;
    end
  end

  // corner is even in both axes, so the offset is an OR
  assign out_valid          = grp_valid_r;
  assign out_data.pixel_x   = grp_r.x0 | PX_W'(dx_r);
  assign out_data.pixel_y   = grp_r.y0 | PY_W'(dy_r);
  assign out_data.red_out   = grp_r.red;
  assign out_data.green_out = grp_r.green;
  assign out_data.blue_out  = grp_r.blue;
  assign out_data.tile_last = tile_last;

  `RGBM_ASSERT_NOW(a_dx_in_tile, grp_valid_r && dx_r, grp_r.tw2, "column step past tile width")
  `RGBM_ASSERT_NOW(a_dy_in_tile, grp_valid_r && dy_r, grp_r.th2, "row step past tile height")
  `RGBM_ASSERT_NOW(a_load_free, grp_load, grp_ready, "tile loaded over a pending tile")
  `RGBM_ASSERT_NEXT(a_last_frees, xfer && tile_last && !grp_load, !grp_valid_r, "tile held after last")

endmodule

>>> rtl/core/rgb_mosaic_2x2_block_average.sv
// ----------------------------------------------------------------------------
// rgb_mosaic_2x2_block_average
// 2x2 block average mosaic over a raster-order RGB pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter on in_valid/in_ready in raster order; width and height come
// from two registers on the cfg_ port (byte addresses 0 and 4). Any write to
// either register restarts the frame at the top-left pixel.
// A tile's results leave on out_valid/out_ready once its lower-right pixel
// has arrived: every pixel of the tile in raster order with its coordinates,
// the truncated tile average and tile_last on the final one.
// Path: the pixel that completes a tile is registered in the work stage, and
// its tile is then loaded into the emit register, from which the first result
// is offered; a tile still playing out there holds the load back.
// Throughput: one pixel per cycle on upper tile rows and for the left pixel
// of each column pair, while no completed tile waits in the work stage. A
// completed tile holds the single output while its pixels play out, and a
// further one waits behind it, so the output paces lower tile rows.
// When out_ready is low the current result holds and in_ready drops once the
// work stage holds a completed tile; other pixels are still taken.
// Reset sets width 1024 and height 768, and clears position and pipeline.
// ----------------------------------------------------------------------------
module rgb_mosaic_2x2_block_average
  import rgbm_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_pixel_t   in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_pixel_t  out_data
);

  geom_t geom;
  grp_t  grp;
  logic  grp_load;
  logic  grp_ready;

  rgbm_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .geom    (geom)
  );

  rgbm_tile #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_tile (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .grp_ready (grp_ready),
    .grp_load  (grp_load),
    .grp       (grp)
  );

  rgbm_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp_load  (grp_load),
    .grp       (grp),
    .grp_ready (grp_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> verif/rgb_mosaic_2x2_block_average_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_mosaic_2x2_block_average_tb
// Streams raster-order pixels through the 2x2 block average mosaic. A local
// tile model predicts each averaged output pixel, and each pixel the block
// emits is compared against the oldest prediction. The register port sets
// the geometry while the stream is idle and is read back after every write. Both
// handshakes stall at random.
// ----------------------------------------------------------------------------
module rgb_mosaic_2x2_block_average_tb;
  import rgbm_pkg::*;

  localparam int MAX_W      = 1024;
  localparam int MAX_H      = 4096;
  localparam int PAIR_SLOTS = (MAX_W + 1) / 2;
  localparam int LAT_TAIL   = 8;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        in_valid;
  logic        in_ready;
  in_pixel_t   in_data;
  logic        out_valid;
  logic        out_ready;
  out_pixel_t  out_data;

  // Tile model state
  logic [CFG_W_W-1:0] img_width;
  logic [CFG_H_W-1:0] img_height;
  int                 col_pos;
  int                 row_pos;
  logic [23:0]        held_left;
  logic [26:0]        upper_sums [PAIR_SLOTS];

  out_pixel_t mosaic_q [$];
  int         mismatch_cnt = 0;
  bit         in_gaps      = 1'b1;
  bit         out_stalls   = 1'b1;

  rgb_mosaic_2x2_block_average #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  function automatic int eff_dim(input int v, input int maxv);
    return (v == 0) ? 1 : ((v > maxv) ? maxv : v);
  endfunction

  function automatic in_pixel_t rand_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return 24'($urandom);
    endcase
  endfunction

  // Advance the tile model by one pixel and queue any averaged outputs
  task automatic average_tile(input in_pixel_t px);
    int         w, h, col, row, slot, tw, th, sh, sr, sg, sb, x0, y0;
    bit         last_col, last_row;
    out_pixel_t o;
    w        = eff_dim(img_width, MAX_W);
    h        = eff_dim(img_height, MAX_H);
    col      = col_pos;
    row      = row_pos;
    last_col = (col + 1 >= w);
    last_row = (row + 1 >= h);
    slot     = (col >> 1) % PAIR_SLOTS;
    if ((col % 2 == 1) || last_col) begin
      tw = (col % 2 == 1) ? 2 : 1;
      sr = px.red_in;
      sg = px.green_in;
      sb = px.blue_in;
      if (tw == 2) begin
        sr += held_left[23:16];
        sg += held_left[15:8];
        sb += held_left[7:0];
      end
      if ((row % 2 == 0) && !last_row) begin
        upper_sums[slot] = {9'(sr), 9'(sg), 9'(sb)};
      end else begin
        th = (row % 2 == 1) ? 2 : 1;
        sh = (tw == 2 ? 1 : 0) + (th == 2 ? 1 : 0);
        x0 = col - (tw - 1);
        y0 = row - (th - 1);
        if (th == 2) begin
          sr += upper_sums[slot][26:18];
          sg += upper_sums[slot][17:9];
          sb += upper_sums[slot][8:0];
        end
        sr = sr >> sh;
        sg = sg >> sh;
        sb = sb >> sh;
        for (int dy = 0; dy < th; dy++) begin
          for (int dx = 0; dx < tw; dx++) begin
            o.pixel_x   = PX_W'(x0 + dx);
            o.pixel_y   = PY_W'(y0 + dy);
            o.red_out   = CH_W'(sr);
            o.green_out = CH_W'(sg);
            o.blue_out  = CH_W'(sb);
            o.tile_last = (dy + 1 == th) && (dx + 1 == tw);
            mosaic_q.push_back(o);
          end
        end
      end
    end else begin
      held_left = px;
    end
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row + 1;
    end else begin
      col_pos = col + 1;
    end
  endtask

  task automatic cfg_access(input logic reg_sel, input bit is_write,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= is_write;
    cfg_paddr   <= {reg_sel, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input logic reg_sel, input logic [31:0] rd);
    logic [31:0] want;
    want = (reg_sel == REG_WIDTH) ? 32'(img_width) : 32'(img_height);
    if (rd !== want)
      report_mismatch($sformatf("register %0d reads %0h, expected %0h", reg_sel, rd, want));
  endtask

  // Only call while idle: the write restarts the frame
  task automatic set_geometry(input logic reg_sel, input int value);
    logic [31:0] rd;
    cfg_access(reg_sel, 1'b1, 32'(value), rd);
    if (reg_sel == REG_WIDTH) img_width = CFG_W_W'(value);
    else img_height = CFG_H_W'(value);
    col_pos = 0;
    row_pos = 0;
    cfg_access(reg_sel, 1'b0, '0, rd);
    check_reg(reg_sel, rd);
  endtask

  // Hold valid until the transfer, then maybe drop it for a burst
  task automatic push_pixel(input in_pixel_t px);
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (!in_ready);
    average_tile(px);
    if (in_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (mosaic_q.size() != 0) @(posedge clk);
    repeat (LAT_TAIL) @(posedge clk);
  endtask

  task automatic push_random(input int n);
    repeat (n) push_pixel(rand_pixel());
  endtask

  task automatic test_reset_values();
    logic [31:0] rd;
    cfg_access(REG_WIDTH, 1'b0, '0, rd);
    check_reg(REG_WIDTH, rd);
    cfg_access(REG_HEIGHT, 1'b0, '0, rd);
    check_reg(REG_HEIGHT, rd);
  endtask

  task automatic test_directed_tiles();
    in_pixel_t odd_frame [9] = '{
      24'hFFFFFF, 24'h000000, 24'h010203,
      24'hFE007F, 24'h00FF80, 24'hAA55FF,
      24'h55AA00, 24'hFF0101, 24'h807FFF
    };
    // 3x3: one full tile, a cut column, a cut row and the corner
    set_geometry(REG_WIDTH, 3);
    set_geometry(REG_HEIGHT, 3);
    foreach (odd_frame[i]) push_pixel(odd_frame[i]);
    // wrap into the next frame's upper row
    push_pixel(24'hFFFFFF);
    push_pixel(24'h000000);
    quiesce();
    set_geometry(REG_WIDTH, 1);
    set_geometry(REG_HEIGHT, 1);
    push_pixel(24'hFFFFFF);
    push_pixel(24'h000000);
    quiesce();
    // abandon a half-built frame; the rewrite must restart at the top left
    set_geometry(REG_WIDTH, 4);
    set_geometry(REG_HEIGHT, 2);
    push_pixel(24'hFFFFFF);
    push_pixel(24'hFFFFFF);
    push_pixel(24'hFFFFFF);
    quiesce();
    set_geometry(REG_WIDTH, 4);
    push_random(8);
    quiesce();
  endtask

  task automatic test_register_extremes();
    // out-of-range values clamp: 2047 -> full width, 0 -> one row
    set_geometry(REG_WIDTH, 2047);
    set_geometry(REG_HEIGHT, 0);
    push_random(12);
    quiesce();
    set_geometry(REG_WIDTH, MAX_W);
    set_geometry(REG_HEIGHT, 2);
    push_random(16);
    quiesce();
    set_geometry(REG_WIDTH, 0);
    set_geometry(REG_HEIGHT, 8191);
    push_random(24);
    quiesce();
    set_geometry(REG_WIDTH, 1);
    set_geometry(REG_HEIGHT, MAX_H);
    push_random(6);
    quiesce();
  endtask

  task automatic test_random_frames(input int target);
    int w, h, n_px, sent;
    bit paused, quiet;
    sent   = 0;
    paused = 1'b0;
    while (sent < target) begin
      if ($urandom_range(0, 7) == 0) begin
        w = $urandom_range(10, 64);
        h = $urandom_range(1, 4);
      end else begin
        w = $urandom_range(1, 9);
        h = $urandom_range(1, 7);
      end
      quiesce();
      if ($urandom_range(0, 1) == 0) begin
        set_geometry(REG_WIDTH, w);
        set_geometry(REG_HEIGHT, h);
      end else begin
        set_geometry(REG_HEIGHT, h);
        if ($urandom_range(0, 3) != 0) set_geometry(REG_WIDTH, w);
      end
      n_px = eff_dim(img_width, MAX_W) * eff_dim(img_height, MAX_H);
      if (n_px <= 64) n_px = n_px * $urandom_range(1, 2);
      // now and then a broken frame, cut short by the next restart
      if ($urandom_range(0, 5) == 0) n_px = $urandom_range(1, n_px);
      quiet = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < n_px && sent < target; i++) begin
        in_gaps    = !quiet && (target - sent > 100);
        out_stalls = !quiet && (target - sent > 100);
        if (!paused && sent >= target / 2) begin
          quiesce();
          paused = 1'b1;
        end
        push_pixel(rand_pixel());
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    out_pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      if (mosaic_q.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel x=%0d y=%0d",
                                  out_data.pixel_x, out_data.pixel_y));
      end else begin
        want = mosaic_q.pop_front();
        if (out_data.pixel_x !== want.pixel_x)
          report_mismatch($sformatf("pixel_x %0d, expected %0d",
                                    out_data.pixel_x, want.pixel_x));
        if (out_data.pixel_y !== want.pixel_y)
          report_mismatch($sformatf("pixel_y %0d, expected %0d",
                                    out_data.pixel_y, want.pixel_y));
        if (out_data.red_out !== want.red_out)
          report_mismatch($sformatf("red_out %0h, expected %0h at (%0d,%0d)",
                                    out_data.red_out, want.red_out, want.pixel_x, want.pixel_y));
        if (out_data.green_out !== want.green_out)
          report_mismatch($sformatf("green_out %0h, expected %0h at (%0d,%0d)",
                                    out_data.green_out, want.green_out, want.pixel_x,
                                    want.pixel_y));
        if (out_data.blue_out !== want.blue_out)
          report_mismatch($sformatf("blue_out %0h, expected %0h at (%0d,%0d)",
                                    out_data.blue_out, want.blue_out, want.pixel_x, want.pixel_y));
        if (out_data.tile_last !== want.tile_last)
          report_mismatch($sformatf("tile_last %0b, expected %0b at (%0d,%0d)",
                                    out_data.tile_last, want.tile_last, want.pixel_x,
                                    want.pixel_y));
      end
    end
  end

  initial begin : result_backpressure
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_stalls && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    img_width   = WIDTH_RST;
    img_height  = HEIGHT_RST;
    col_pos     = 0;
    row_pos     = 0;
    held_left   = '0;
    foreach (upper_sums[i]) upper_sums[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_directed_tiles();
    test_register_extremes();
    test_random_frames(350);
    quiesce();
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
